// ----- hw/rtl/clcd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clcd_pkg
// Sizes, codes and shared types of the character LCD text terminal.
// ----------------------------------------------------------------------------
package clcd_pkg;

	localparam int NUM_COLS = 16;
	localparam int NUM_ROWS = 2;
	localparam int TAB_STOP = 4;

	localparam int DEPTH = NUM_ROWS * NUM_COLS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int COL_W = $clog2(NUM_COLS + 1);
	localparam int ROW_W = $clog2(NUM_ROWS + 1);
	localparam int CI_W = $clog2(NUM_COLS);
	localparam int COPY_N = (NUM_ROWS - 1) * NUM_COLS;
	localparam int MASK_N = 2 ** COL_W;

	localparam logic [1:0] CMD_PRINT = 2'd0;
	localparam logic [1:0] CMD_BEGIN = 2'd1;
	localparam logic [1:0] CMD_END = 2'd2;

	localparam logic [7:0] CH_BS = 8'h08;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_FF = 8'h0C;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam logic [7:0] SET_DDRAM = 8'h80;
	localparam logic [7:0] ROW_ODD_OFS = 8'h40;

	// columns that are tab stops
	function automatic logic [MASK_N-1:0] tab_mask();
		logic [MASK_N-1:0] m;
		m = '0;
		for (int i = 0; i < MASK_N; i++) begin
			m[i] = ((i % TAB_STOP) == 0);
		end
		return m;
	endfunction

	localparam logic [MASK_N-1:0] TAB_MASK = tab_mask();

	// set-ddram-address command for a row
	function automatic logic [7:0] ddram_cmd(input logic [ROW_W-1:0] r);
		logic [2:0] rx;
		logic [7:0] a;
		rx = 3'(r);
		a = SET_DDRAM;
		if (rx[0]) begin
			a = a + ROW_ODD_OFS;
		end
		if (rx[1]) begin
			a = a + 8'(NUM_COLS);
		end
		return a;
	endfunction

	typedef struct packed {
		logic latch;
		logic set_batch;
		logic clr_batch;
		logic bs;
		logic cr;
		logic lf;
		logic ff;
		logic wrap;
		logic store_char;
		logic store_space;
		logic scr_rd;
		logic scr_wr;
		logic scr_clr;
		logic rdr_start;
		logic emit_addr;
		logic emit_cell;
	} ctl_cmd_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic is_bs;
		logic is_cr;
		logic is_lf;
		logic is_ff;
		logic is_tab;
		logic batching;
		logic row_full;
		logic tab_stop;
		logic scr_last;
		logic out_free;
		logic rdr_last_col;
		logic rdr_last_row;
	} dp_stat_t;

endpackage

// ----- hw/rtl/char_lcd_text_terminal_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_text_terminal_top
// Text terminal that keeps a character screen and streams LCD redraws.
// ----------------------------------------------------------------------------
// One transaction is taken at a time; in_stall stays high until its work and
// any redraw are done. A printed character that runs past the last row first
// scrolls the screen, copying each cell below the first row up by one row and
// then clearing the last row. A tab stores spaces up to the next tab stop in
// place of the single character store. A redraw then streams
// rows*(cols+1) bytes, 34 at 2x16, one per cycle through the screen store
// and the output register, slower only when out_stall is held.
// The screen is empty straight out of reset, with no clearing pass.
module char_lcd_text_terminal_top import clcd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [7:0]  char_code,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        is_data,
	output logic [7:0]  lcd_byte,
	output logic        last
);

	ctl_cmd_t ctl;
	dp_stat_t stat;

	clcd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.ctl      (ctl)
	);

	clcd_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.char_code (char_code),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.is_data   (is_data),
		.lcd_byte  (lcd_byte),
		.last      (last),
		.ctl       (ctl),
		.stat      (stat)
	);

endmodule

// ----- hw/rtl/clcd_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clcd_ctrl
// Sequencer: decodes a transaction, steps cursor, scroll and redraw.
// ----------------------------------------------------------------------------
module clcd_ctrl import clcd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  dp_stat_t  stat,
	output ctl_cmd_t  ctl
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DECODE = 4'd1;
	localparam logic [3:0] S_WRAP = 4'd2;
	localparam logic [3:0] S_SCRCHK = 4'd3;
	localparam logic [3:0] S_SCR_RD = 4'd4;
	localparam logic [3:0] S_SCR_WR = 4'd5;
	localparam logic [3:0] S_SCR_CLR = 4'd6;
	localparam logic [3:0] S_STORE = 4'd7;
	localparam logic [3:0] S_TAB = 4'd8;
	localparam logic [3:0] S_TAB_CHK = 4'd9;
	localparam logic [3:0] S_FINISH = 4'd10;
	localparam logic [3:0] S_RDR_ADDR = 4'd11;
	localparam logic [3:0] S_RDR_CELL = 4'd12;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		ctl = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctl.latch = 1'b1;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				case (stat.cmd)
					CMD_PRINT: begin
						if (stat.is_bs) begin
							ctl.bs = 1'b1;
							state_d = S_FINISH;
						end else if (stat.is_cr) begin
							ctl.cr = 1'b1;
							state_d = S_FINISH;
						end else if (stat.is_lf) begin
							ctl.lf = 1'b1;
							state_d = S_FINISH;
						end else if (stat.is_ff) begin
							ctl.ff = 1'b1;
							state_d = S_FINISH;
						end else begin
							state_d = S_WRAP;
						end
					end
					CMD_BEGIN: begin
						ctl.set_batch = 1'b1;
						state_d = S_IDLE;
					end
					CMD_END: begin
						if (stat.batching) begin
							ctl.clr_batch = 1'b1;
							ctl.rdr_start = 1'b1;
							state_d = S_RDR_ADDR;
						end else begin
							state_d = S_IDLE;
						end
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_WRAP: begin
				ctl.wrap = 1'b1;
				state_d = S_SCRCHK;
			end
			S_SCRCHK: begin
				if (stat.row_full) begin
					state_d = (COPY_N == 0) ? S_SCR_CLR : S_SCR_RD;
				end else begin
					state_d = stat.is_tab ? S_TAB : S_STORE;
				end
			end
			S_SCR_RD: begin
				ctl.scr_rd = 1'b1;
				state_d = S_SCR_WR;
			end
			S_SCR_WR: begin
				ctl.scr_wr = 1'b1;
				state_d = stat.scr_last ? S_SCR_CLR : S_SCR_RD;
			end
			S_SCR_CLR: begin
				ctl.scr_clr = 1'b1;
				state_d = stat.is_tab ? S_TAB : S_STORE;
			end
			S_STORE: begin
				ctl.store_char = 1'b1;
				state_d = S_FINISH;
			end
			S_TAB: begin
				ctl.store_space = 1'b1;
				state_d = S_TAB_CHK;
			end
			S_TAB_CHK: begin
				state_d = stat.tab_stop ? S_FINISH : S_TAB;
			end
			S_FINISH: begin
				if (stat.batching) begin
					state_d = S_IDLE;
				end else begin
					ctl.rdr_start = 1'b1;
					state_d = S_RDR_ADDR;
				end
			end
			S_RDR_ADDR: begin
				if (stat.out_free) begin
					ctl.emit_addr = 1'b1;
					state_d = S_RDR_CELL;
				end
			end
			S_RDR_CELL: begin
				if (stat.out_free) begin
					ctl.emit_cell = 1'b1;
					if (stat.rdr_last_col) begin
						state_d = stat.rdr_last_row ? S_IDLE : S_RDR_ADDR;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- hw/rtl/clcd_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clcd_dp
// Datapath: screen store, cursor, batching flag and output register.
// ----------------------------------------------------------------------------
module clcd_dp import clcd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [1:0]  cmd,
	input  logic [7:0]  char_code,
	input  logic        out_stall,
	output logic        out_valid,
	output logic        is_data,
	output logic [7:0]  lcd_byte,
	output logic        last,
	input  ctl_cmd_t    ctl,
	output dp_stat_t    stat
);

	logic [1:0]        cmd_q;
	logic [7:0]        char_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic              batch_q;
	logic [ADDR_W-1:0] scr_cnt_q;
	logic [ROW_W-1:0]  rdr_row_q;
	logic [CI_W-1:0]   rdr_col_q;

	logic [7:0]        mem_q [DEPTH];
	logic [DEPTH-1:0]  vld_q;
	logic [7:0]        rd_q;
	logic              rd_vld_q;

	logic              out_valid_q;
	logic              is_data_q;
	logic [7:0]        lcd_byte_q;
	logic              last_q;

	logic              col_full;
	logic              row_full;
	logic              rdr_last_col;
	logic              rdr_last_row;
	logic [7:0]        rd_byte;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [7:0]        wr_data;
	logic              out_load;

	assign col_full = (col_q >= COL_W'(NUM_COLS));
	assign row_full = (row_q >= ROW_W'(NUM_ROWS));
	assign rdr_last_col = (rdr_col_q == CI_W'(NUM_COLS - 1));
	assign rdr_last_row = (rdr_row_q == ROW_W'(NUM_ROWS - 1));
	assign rd_byte = rd_vld_q ? rd_q : 8'h00;
	assign out_load = ctl.emit_addr | ctl.emit_cell;

	// read port: scroll source, or the next cell of the redraw
	always_comb begin
		rd_en = 1'b0;
		rd_addr = '0;
		if (ctl.scr_rd) begin
			rd_en = 1'b1;
			rd_addr = ADDR_W'(int'(scr_cnt_q) + NUM_COLS);
		end else if (ctl.emit_addr) begin
			rd_en = 1'b1;
			rd_addr = ADDR_W'(int'(rdr_row_q) * NUM_COLS);
		end else if (ctl.emit_cell && !rdr_last_col) begin
			rd_en = 1'b1;
			rd_addr = ADDR_W'(int'(rdr_row_q) * NUM_COLS + int'(rdr_col_q) + 1);
		end
	end

	// write port: scroll copy, or character or tab space at the cursor
	always_comb begin
		wr_en = 1'b0;
		wr_addr = ADDR_W'(int'(row_q) * NUM_COLS + int'(col_q));
		wr_data = char_q;
		if (ctl.scr_wr) begin
			wr_en = 1'b1;
			wr_addr = scr_cnt_q;
			wr_data = rd_byte;
		end else if (ctl.store_char) begin
			wr_en = 1'b1;
		end else if (ctl.store_space) begin
			wr_en = 1'b1;
			wr_data = CH_SPACE;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
			if (ctl.ff) begin
				vld_q <= '0;
			end else if (ctl.scr_clr) begin
				for (int i = COPY_N; i < DEPTH; i++) begin
					vld_q[i] <= 1'b0;
				end
			end else if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			cmd_q <= cmd;
			char_q <= char_code;
		end
	end

	// cursor, batching flag, scroll and redraw counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			batch_q <= 1'b0;
			scr_cnt_q <= '0;
			rdr_row_q <= '0;
			rdr_col_q <= '0;
		end else begin
			if (ctl.set_batch) begin
				batch_q <= 1'b1;
			end else if (ctl.clr_batch) begin
				batch_q <= 1'b0;
			end

			if (ctl.bs) begin
				if (col_q != '0) begin
					col_q <= col_q - 1'b1;
				end
			end else if (ctl.cr) begin
				col_q <= '0;
			end else if (ctl.lf) begin
				if (!row_full) begin
					row_q <= row_q + 1'b1;
				end
			end else if (ctl.ff) begin
				col_q <= '0;
				row_q <= '0;
			end else if (ctl.wrap) begin
				if (col_full) begin
					col_q <= '0;
					if (!row_full) begin
						row_q <= row_q + 1'b1;
					end
				end
			end else if (ctl.scr_clr) begin
				row_q <= ROW_W'(NUM_ROWS - 1);
			end else if (ctl.store_char || ctl.store_space) begin
				col_q <= col_q + 1'b1;
			end

			if (ctl.scr_clr) begin
				scr_cnt_q <= '0;
			end else if (ctl.scr_wr) begin
				scr_cnt_q <= scr_cnt_q + 1'b1;
			end

			if (ctl.rdr_start) begin
				rdr_row_q <= '0;
				rdr_col_q <= '0;
			end else if (ctl.emit_cell) begin
				if (rdr_last_col) begin
					rdr_col_q <= '0;
					rdr_row_q <= rdr_row_q + 1'b1;
				end else begin
					rdr_col_q <= rdr_col_q + 1'b1;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit_addr) begin
			is_data_q <= 1'b0;
			lcd_byte_q <= ddram_cmd(rdr_row_q);
			last_q <= 1'b0;
		end else if (ctl.emit_cell) begin
			is_data_q <= 1'b1;
			lcd_byte_q <= (rd_byte == 8'h00) ? CH_SPACE : rd_byte;
			last_q <= rdr_last_col & rdr_last_row;
		end
	end

	assign out_valid = out_valid_q;
	assign is_data = is_data_q;
	assign lcd_byte = lcd_byte_q;
	assign last = last_q;

	always_comb begin
		stat.cmd = cmd_q;
		stat.is_bs = (char_q == CH_BS);
		stat.is_cr = (char_q == CH_CR);
		stat.is_lf = (char_q == CH_LF);
		stat.is_ff = (char_q == CH_FF);
		stat.is_tab = (char_q == CH_TAB);
		stat.batching = batch_q;
		stat.row_full = row_full;
		stat.tab_stop = col_full | TAB_MASK[col_q];
		stat.scr_last = (scr_cnt_q == ADDR_W'(COPY_N - 1));
		stat.out_free = !out_valid_q || !out_stall;
		stat.rdr_last_col = rdr_last_col;
		stat.rdr_last_row = rdr_last_row;
	end

endmodule

// ----- tb/sv/lcd_redraw_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_redraw_checker
// Watches both channels of the text terminal and keeps its own copy of the
// screen, cursor and batching flag. It builds the bytes of every redraw that
// an accepted transaction calls for, then checks each streamed LCD byte,
// field by field, against the oldest byte still owed.
// ----------------------------------------------------------------------------
module lcd_redraw_checker import clcd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [1:0] cmd,
	input  logic [7:0] char_code,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic       is_data,
	input  logic [7:0] lcd_byte,
	input  logic       last,
	output int         mismatches,
	output int         bytes_owed
);

	typedef struct {
		logic       is_data;
		logic [7:0] code;
		logic       last;
	} lcd_xfer_t;

	logic [7:0]       screen [NUM_ROWS][NUM_COLS];
	logic [COL_W-1:0] cur_col;
	logic [ROW_W-1:0] cur_row;
	logic             in_batch;
	lcd_xfer_t        owed_q [$];

	task automatic report(input string what, input int got, input int want);
		$display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
		mismatches++;
	endtask

	task automatic clear_screen();
		for (int r = 0; r < NUM_ROWS; r++) begin
			for (int c = 0; c < NUM_COLS; c++) begin
				screen[r][c] = 8'h00;
			end
		end
	endtask

	task automatic scroll_up();
		for (int r = 0; r < NUM_ROWS - 1; r++) begin
			for (int c = 0; c < NUM_COLS; c++) begin
				screen[r][c] = screen[r + 1][c];
			end
		end
		for (int c = 0; c < NUM_COLS; c++) begin
			screen[NUM_ROWS - 1][c] = 8'h00;
		end
	endtask

	task automatic wrap_and_scroll();
		if (cur_col >= NUM_COLS) begin
			cur_col = '0;
			if (cur_row < NUM_ROWS) begin
				cur_row = cur_row + 1'b1;
			end
		end
		if (cur_row >= NUM_ROWS) begin
			scroll_up();
			cur_row = ROW_W'(NUM_ROWS - 1);
		end
	endtask

	task automatic put_char(input logic [7:0] ch);
		int n;
		case (ch)
			CH_BS: begin
				if (cur_col != 0) begin
					cur_col = cur_col - 1'b1;
				end
			end
			CH_CR: begin
				cur_col = '0;
			end
			CH_LF: begin
				if (cur_row < NUM_ROWS) begin
					cur_row = cur_row + 1'b1;
				end
			end
			CH_FF: begin
				clear_screen();
				cur_col = '0;
				cur_row = '0;
			end
			CH_TAB: begin
				wrap_and_scroll();
				n = ((int'(cur_col) + TAB_STOP) / TAB_STOP) * TAB_STOP - int'(cur_col);
				while (cur_col < NUM_COLS && n > 0) begin
					screen[cur_row][cur_col] = CH_SPACE;
					cur_col = cur_col + 1'b1;
					n--;
				end
			end
			default: begin
				wrap_and_scroll();
				screen[cur_row][cur_col] = ch;
				cur_col = cur_col + 1'b1;
			end
		endcase
	endtask

	task automatic queue_redraw();
		lcd_xfer_t  x;
		logic [7:0] addr;
		for (int r = 0; r < NUM_ROWS; r++) begin
			addr = SET_DDRAM;
			if ((r & 1) != 0) begin
				addr = addr + ROW_ODD_OFS;
			end
			if ((r & 2) != 0) begin
				addr = addr + 8'(NUM_COLS);
			end
			x.is_data = 1'b0;
			x.code = addr;
			x.last = 1'b0;
			owed_q.push_back(x);
			for (int c = 0; c < NUM_COLS; c++) begin
				x.is_data = 1'b1;
				x.code = (screen[r][c] == 8'h00) ? CH_SPACE : screen[r][c];
				x.last = (r == NUM_ROWS - 1) && (c == NUM_COLS - 1);
				owed_q.push_back(x);
			end
		end
	endtask

	task automatic take_transaction(input logic [1:0] c, input logic [7:0] ch);
		case (c)
			CMD_PRINT: begin
				put_char(ch);
				if (!in_batch) begin
					queue_redraw();
				end
			end
			CMD_BEGIN: begin
				in_batch = 1'b1;
			end
			CMD_END: begin
				if (in_batch) begin
					in_batch = 1'b0;
					queue_redraw();
				end
			end
			default: begin
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		lcd_xfer_t want;
		if (!arst_n) begin
			clear_screen();
			cur_col = '0;
			cur_row = '0;
			in_batch = 1'b0;
			owed_q.delete();
			mismatches = 0;
			bytes_owed <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				take_transaction(cmd, char_code);
			end
			if (out_valid && !out_stall) begin
				if (owed_q.size() == 0) begin
					report("byte with nothing owed", lcd_byte, 0);
				end else begin
					want = owed_q.pop_front();
					if (is_data !== want.is_data) begin
						report("is_data", is_data, want.is_data);
					end
					if (lcd_byte !== want.code) begin
						report("lcd_byte", lcd_byte, want.code);
					end
					if (last !== want.last) begin
						report("last", last, want.last);
					end
				end
			end
			bytes_owed <= owed_q.size();
		end
	end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the text terminal with a directed run of printing, control
// characters, batching and unused commands, then with random text and
// batches, both sides idling at random but in a calm stretch. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
	import clcd_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [1:0] cmd = CMD_PRINT;
	logic [7:0] char_code = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       is_data;
	logic [7:0] lcd_byte;
	logic       last;
	int         mismatches;
	int         bytes_owed;
	bit         calm = 1'b0;

	char_lcd_text_terminal_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.char_code (char_code),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.is_data   (is_data),
		.lcd_byte  (lcd_byte),
		.last      (last)
	);

	lcd_redraw_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.char_code  (char_code),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.is_data    (is_data),
		.lcd_byte   (lcd_byte),
		.last       (last),
		.mismatches (mismatches),
		.bytes_owed (bytes_owed)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		out_stall <= !calm && ($urandom_range(0, 99) < 28);
	end

	task automatic send(input logic [1:0] c, input logic [7:0] ch);
		while (!calm && $urandom_range(0, 99) < 28) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		char_code <= ch;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
	endtask

	function automatic logic [7:0] pick_char();
		logic [7:0] ctl [5];
		ctl = '{CH_BS, CH_TAB, CH_LF, CH_FF, CH_CR};
		if ($urandom_range(0, 99) < 22) begin
			return ctl[$urandom_range(0, 4)];
		end
		return 8'($urandom_range(0, 255));
	endfunction

	initial begin
		int n_items;
		int len;
		int pick;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, every control character, wrap, scroll, batching
		send(CMD_PRINT, 8'h48);
		send(CMD_PRINT, 8'h00);
		send(CMD_PRINT, 8'hFF);
		send(CMD_PRINT, CH_BS);
		send(CMD_PRINT, CH_CR);
		send(CMD_PRINT, CH_BS);
		send(CMD_PRINT, CH_LF);
		send(CMD_PRINT, CH_LF);
		send(CMD_PRINT, CH_LF);
		send(CMD_PRINT, 8'h78);
		send(CMD_PRINT, CH_TAB);
		send(CMD_BEGIN, 8'hFF);
		send(CMD_PRINT, CH_TAB);
		send(CMD_PRINT, CH_TAB);
		send(CMD_PRINT, CH_TAB);
		send(CMD_PRINT, CH_TAB);
		send(CMD_BEGIN, 8'h00);
		send(CMD_END, 8'hAA);
		send(CMD_END, 8'h55);
		send(CMD_UNUSED, 8'h7A);
		send(CMD_PRINT, CH_FF);
		send(CMD_PRINT, 8'h7F);
		send(CMD_BEGIN, 8'h80);
		send(CMD_UNUSED, 8'hFF);
		send(CMD_END, 8'h01);

		// random text, batches and stray commands
		n_items = 0;
		while (n_items < 105) begin
			calm = (n_items >= 40) && (n_items < 75);
			pick = $urandom_range(0, 99);
			if (pick < 12) begin
				len = $urandom_range(1, 40);
				send(CMD_BEGIN, 8'($urandom));
				repeat (len) send(CMD_PRINT, pick_char());
				send(CMD_END, 8'($urandom));
				n_items += len + 2;
			end else if (pick < 16) begin
				send(CMD_UNUSED, 8'($urandom));
				n_items++;
			end else if (pick < 20) begin
				send(($urandom_range(0, 1) != 0) ? CMD_BEGIN : CMD_END, 8'($urandom));
				n_items++;
			end else begin
				send(CMD_PRINT, pick_char());
				n_items++;
			end
		end
		calm = 1'b0;

		in_valid <= 1'b0;
		@(posedge clk);
		while (bytes_owed != 0) begin
			@(posedge clk);
		end
		repeat (100) @(posedge clk);
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

endmodule
